### hdl/bsab_pkg.sv
// bsab_pkg: types, constants and helper functions for the bilinear sample and alpha blend pipeline
// no dependencies
package bsab_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int COORD_BITS = 12;
	localparam int CH_W       = 8;
	localparam int S_W        = FRAC_BITS + 1;
	localparam int H_W        = CH_W + FRAC_BITS;
	localparam int P_W        = CH_W + 2 * FRAC_BITS + 1;
	localparam int SH         = 2 * FRAC_BITS - 8;
	localparam int RND        = (SH == 0) ? 0 : (1 << ((SH == 0) ? 0 : SH - 1));
	localparam int V_W        = 16;
	localparam int A_W        = 25;
	localparam int NUM_W      = 44;
	localparam int DEN_W      = 34;
	localparam int Q_W        = 9;
	localparam int NLANE      = 4;
	localparam int NCOL       = 3;
	localparam int CFG_IDX_W  = 1;

	localparam logic [V_W-1:0]       ONE88     = V_W'(255 * 256);
	localparam logic [CFG_IDX_W-1:0] REG_INTERP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND  = 1'b1;

	typedef struct packed {
		logic [31:0]           texel_top_left;
		logic [31:0]           texel_top_right;
		logic [31:0]           texel_bottom_left;
		logic [31:0]           texel_bottom_right;
		logic [FRAC_BITS-1:0]  frac_x;
		logic [FRAC_BITS-1:0]  frac_y;
		logic [31:0]           dest_color;
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} in_item_t;

	typedef struct packed {
		logic [31:0]           result_color;
		logic [COORD_BITS-1:0] result_x;
		logic [COORD_BITS-1:0] result_y;
	} out_item_t;

	typedef struct packed {
		logic interp;
		logic blend;
	} mode_t;

	typedef struct packed {
		logic [31:0]           plain;
		logic                  blend;
		logic                  a_zero;
		logic [CH_W-1:0]       alpha;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} side_t;

	typedef logic [V_W-1:0]   v88_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [DEN_W-1:0] den_t;
	typedef logic [Q_W-1:0]   quo_t;

	function automatic logic [CH_W-1:0] chan(input logic [31:0] w, input logic [1:0] k);
		logic [31:0] t;
		t = w >> (5'd24 - {k, 3'b000});
		return t[CH_W-1:0];
	endfunction

	function automatic logic [CH_W-1:0] sat8(input quo_t q);
		return (q > Q_W'(255)) ? 8'hFF : q[CH_W-1:0];
	endfunction

	function automatic logic [CH_W-1:0] round88(input v88_t v);
		logic [V_W:0] t;
		t = {1'b0, v} + (V_W+1)'(128);
		return t[V_W] ? 8'hFF : t[V_W-1:8];
	endfunction

endpackage

### hdl/bsab_interp.sv
// bsab_interp: two-stage bilinear interpolation of four RGBA texels to 8.8 channels
// depends on bsab_pkg; with mode.interp low, stage 2 passes the top-left texel instead
module bsab_interp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  bsab_pkg::mode_t    mode,
	input  bsab_pkg::in_item_t item,
	output logic               valid_s2,
	output bsab_pkg::v88_t     v_s2 [bsab_pkg::NLANE],
	output bsab_pkg::in_item_t item_s2,
	output bsab_pkg::mode_t    mode_s2
);

	localparam logic [bsab_pkg::S_W-1:0] S_ONE = bsab_pkg::S_W'(1) << bsab_pkg::FRAC_BITS;

	logic                         valid_s1;
	bsab_pkg::in_item_t           item_s1;
	bsab_pkg::mode_t              mode_s1;
	logic [bsab_pkg::H_W-1:0]     top_s1 [bsab_pkg::NLANE];
	logic [bsab_pkg::H_W-1:0]     bot_s1 [bsab_pkg::NLANE];
	logic [bsab_pkg::H_W-1:0]     top_c  [bsab_pkg::NLANE];
	logic [bsab_pkg::H_W-1:0]     bot_c  [bsab_pkg::NLANE];
	bsab_pkg::v88_t               v_c    [bsab_pkg::NLANE];
	logic [bsab_pkg::S_W-1:0]     wx, wy;

	always_comb begin
		wx = S_ONE - bsab_pkg::S_W'(item.frac_x);
		for (int k = 0; k < bsab_pkg::NLANE; k++) begin
			top_c[k] = bsab_pkg::H_W'(
				bsab_pkg::H_W'(bsab_pkg::chan(item.texel_top_left, 2'(k))) * bsab_pkg::H_W'(wx) +
				bsab_pkg::H_W'(bsab_pkg::chan(item.texel_top_right, 2'(k))) *
				bsab_pkg::H_W'(item.frac_x));
			bot_c[k] = bsab_pkg::H_W'(
				bsab_pkg::H_W'(bsab_pkg::chan(item.texel_bottom_left, 2'(k))) * bsab_pkg::H_W'(wx) +
				bsab_pkg::H_W'(bsab_pkg::chan(item.texel_bottom_right, 2'(k))) *
				bsab_pkg::H_W'(item.frac_x));
		end
	end

	always_comb begin
		logic [bsab_pkg::P_W-1:0] p;
		wy = S_ONE - bsab_pkg::S_W'(item_s1.frac_y);
		for (int k = 0; k < bsab_pkg::NLANE; k++) begin
			p = bsab_pkg::P_W'(bsab_pkg::P_W'(top_s1[k]) * bsab_pkg::P_W'(wy) +
				bsab_pkg::P_W'(bot_s1[k]) * bsab_pkg::P_W'(item_s1.frac_y)) +
				bsab_pkg::P_W'(bsab_pkg::RND);
			if (mode_s1.interp) begin
				v_c[k] = bsab_pkg::V_W'(p >> bsab_pkg::SH);
			end else begin
				v_c[k] = {bsab_pkg::chan(item_s1.texel_top_left, 2'(k)), 8'h00};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
		mode_s1 <= mode;
		top_s1  <= top_c;
		bot_s1  <= bot_c;
		item_s2 <= item_s1;
		mode_s2 <= mode_s1;
		v_s2    <= v_c;
	end

endmodule

### hdl/bsab_blend_prep.sv
// bsab_blend_prep: two stages forming the over-blend numerators, denominators and output alpha
// depends on bsab_pkg
module bsab_blend_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s2,
	input  bsab_pkg::v88_t     v_s2 [bsab_pkg::NLANE],
	input  bsab_pkg::in_item_t item_s2,
	input  bsab_pkg::mode_t    mode_s2,
	output logic               valid_s4,
	output bsab_pkg::num_t     num_s4 [bsab_pkg::NCOL],
	output bsab_pkg::den_t     den_s4 [bsab_pkg::NCOL],
	output bsab_pkg::side_t    side_s4
);

	logic                     valid_s3;
	bsab_pkg::side_t          side_s3;
	logic [bsab_pkg::V_W-1:0] inv_s3;
	logic [bsab_pkg::A_W-1:0] a_s3;
	logic [31:0]              vcva_s3 [3];
	logic [15:0]              dcda_s3 [3];
	bsab_pkg::side_t          side_c;
	bsab_pkg::side_t          side_n;
	logic [bsab_pkg::V_W-1:0] inv_c;
	logic [7:0]               da;
	logic [bsab_pkg::A_W-1:0] a_half;
	logic [16:0]              a_div;
	logic [16:0]              a_quo;

	always_comb begin
		da    = bsab_pkg::chan(item_s2.dest_color, 2'd3);
		inv_c = bsab_pkg::ONE88 - v_s2[3];
		side_c.plain  = {bsab_pkg::round88(v_s2[0]), bsab_pkg::round88(v_s2[1]),
			bsab_pkg::round88(v_s2[2]), bsab_pkg::round88(v_s2[3])};
		side_c.blend  = mode_s2.blend;
		side_c.a_zero = 1'b0;
		side_c.alpha  = '0;
		side_c.x      = item_s2.pixel_x;
		side_c.y      = item_s2.pixel_y;
	end

	// output alpha: a over 255*256 rounded, as a shift by 8 then a divide by 255
	always_comb begin
		a_half = a_s3 + bsab_pkg::A_W'(bsab_pkg::ONE88 >> 1);
		a_div  = a_half[bsab_pkg::A_W-1:8];
		a_quo  = a_div + 17'd1 + 17'(a_div[16:8]);
		side_n        = side_s3;
		side_n.a_zero = (a_s3 == '0);
		side_n.alpha  = a_quo[15:8];
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_c;
		inv_s3  <= inv_c;
		a_s3    <= bsab_pkg::A_W'(bsab_pkg::A_W'(v_s2[3]) * bsab_pkg::A_W'(255) +
			bsab_pkg::A_W'(da) * bsab_pkg::A_W'(inv_c));
		for (int k = 0; k < 3; k++) begin
			vcva_s3[k] <= 32'(v_s2[k]) * 32'(v_s2[3]);
			dcda_s3[k] <= 16'(bsab_pkg::chan(item_s2.dest_color, 2'(k))) * 16'(da);
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_n;
		for (int k = 0; k < 3; k++) begin
			num_s4[k] <= bsab_pkg::NUM_W'(
				(bsab_pkg::NUM_W'(vcva_s3[k]) * bsab_pkg::NUM_W'(255) +
				(bsab_pkg::NUM_W'(32'(dcda_s3[k]) * 32'(inv_s3)) << 8)) << 1) +
				(bsab_pkg::NUM_W'(a_s3) << 8);
			den_s4[k] <= bsab_pkg::DEN_W'(a_s3) << 9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

endmodule

### hdl/bsab_div.sv
// bsab_div: pipelined restoring divider, one quotient bit per stage
// depends on bsab_pkg
module bsab_div (
	input  logic           clk,
	input  bsab_pkg::num_t num,
	input  bsab_pkg::den_t den,
	output bsab_pkg::quo_t quo
);

	bsab_pkg::num_t rem_s [bsab_pkg::Q_W+1];
	bsab_pkg::den_t den_s [bsab_pkg::Q_W+1];
	bsab_pkg::quo_t q_s   [bsab_pkg::Q_W+1];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign q_s[0]   = '0;
	assign quo      = q_s[bsab_pkg::Q_W];

	for (genvar i = 0; i < bsab_pkg::Q_W; i++) begin : g_stage
		localparam int B = bsab_pkg::Q_W - 1 - i;
		logic [bsab_pkg::NUM_W:0] dsh;
		logic                     ge;

		always_comb begin
			dsh = (bsab_pkg::NUM_W+1)'(den_s[i]) << B;
			ge  = ({1'b0, rem_s[i]} >= dsh);
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? rem_s[i] - dsh[bsab_pkg::NUM_W-1:0] : rem_s[i];
			den_s[i+1] <= den_s[i];
			q_s[i+1]   <= q_s[i] | (ge ? (bsab_pkg::Q_W'(1) << B) : '0);
		end
	end

endmodule

### hdl/bilinear_sample_alpha_blend.sv
// bilinear_sample_alpha_blend: top level, texel interpolation then over-blend with division
// depends on bsab_pkg, bsab_interp, bsab_blend_prep, bsab_div
// start to done passes through two interpolation stages, two blend set-up
// stages, nine divider stages for the colour channels (one quotient bit each) and the
// output register
// throughput one transaction per cycle; busy is always low and the receiver cannot stall
// reset clears the valid bits and sets both mode registers to 1
module bilinear_sample_alpha_blend (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  bsab_pkg::in_item_t               pixel_in,
	output logic                             done,
	output bsab_pkg::out_item_t              pixel_out,
	input  logic                             cfg_we,
	input  logic [bsab_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                             cfg_data
);

	logic               interp_q, blend_q;
	bsab_pkg::mode_t    mode;
	logic               valid_s2, valid_s4;
	bsab_pkg::v88_t     v_s2 [bsab_pkg::NLANE];
	bsab_pkg::in_item_t item_s2;
	bsab_pkg::mode_t    mode_s2;
	bsab_pkg::num_t     num_s4 [bsab_pkg::NCOL];
	bsab_pkg::den_t     den_s4 [bsab_pkg::NCOL];
	bsab_pkg::side_t    side_s4;
	bsab_pkg::quo_t     quo [bsab_pkg::NCOL];
	logic               dv_valid_s [bsab_pkg::Q_W];
	bsab_pkg::side_t    dv_side_s  [bsab_pkg::Q_W];
	bsab_pkg::side_t    side_end;
	logic [31:0]        color;

	assign busy = 1'b0;
	assign mode = '{interp: interp_q, blend: blend_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_q <= 1'b1;
			blend_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				bsab_pkg::REG_INTERP: interp_q <= cfg_data;
				bsab_pkg::REG_BLEND:  blend_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	bsab_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start & ~busy),
		.mode     (mode),
		.item     (pixel_in),
		.valid_s2 (valid_s2),
		.v_s2     (v_s2),
		.item_s2  (item_s2),
		.mode_s2  (mode_s2)
	);

	bsab_blend_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.v_s2     (v_s2),
		.item_s2  (item_s2),
		.mode_s2  (mode_s2),
		.valid_s4 (valid_s4),
		.num_s4   (num_s4),
		.den_s4   (den_s4),
		.side_s4  (side_s4)
	);

	for (genvar k = 0; k < bsab_pkg::NCOL; k++) begin : g_lane
		bsab_div u_div (
			.clk (clk),
			.num (num_s4[k]),
			.den (den_s4[k]),
			.quo (quo[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bsab_pkg::Q_W; i++) begin
				dv_valid_s[i] <= 1'b0;
			end
			done <= 1'b0;
		end else begin
			dv_valid_s[0] <= valid_s4;
			for (int i = 1; i < bsab_pkg::Q_W; i++) begin
				dv_valid_s[i] <= dv_valid_s[i-1];
			end
			done <= dv_valid_s[bsab_pkg::Q_W-1];
		end
	end

	always_ff @(posedge clk) begin
		dv_side_s[0] <= side_s4;
		for (int i = 1; i < bsab_pkg::Q_W; i++) begin
			dv_side_s[i] <= dv_side_s[i-1];
		end
	end

	always_comb begin
		side_end = dv_side_s[bsab_pkg::Q_W-1];
		color    = side_end.plain;
		if (side_end.blend) begin
			color[7:0] = side_end.alpha;
			if (!side_end.a_zero) begin
				color[31:24] = bsab_pkg::sat8(quo[0]);
				color[23:16] = bsab_pkg::sat8(quo[1]);
				color[15:8]  = bsab_pkg::sat8(quo[2]);
			end
		end
	end

	always_ff @(posedge clk) begin
		pixel_out.result_color <= color;
		pixel_out.result_x     <= side_end.x;
		pixel_out.result_y     <= side_end.y;
	end

endmodule

### tb/bilinear_sample_alpha_blend_tb.sv
// bilinear_sample_alpha_blend_tb: self-checking bench for the bilinear sample and over-blend block
// predicts each pixel colour in fixed point and checks every done strobe in order
// depends on bsab_pkg and bilinear_sample_alpha_blend
module bilinear_sample_alpha_blend_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 14;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	bsab_pkg::in_item_t pixel_in = '0;
	logic done;
	bsab_pkg::out_item_t pixel_out;
	logic cfg_we = 1'b0;
	logic [bsab_pkg::CFG_IDX_W-1:0] cfg_index = bsab_pkg::REG_INTERP;
	logic cfg_data = 1'b0;

	bsab_pkg::in_item_t pending_pixels[$];
	bsab_pkg::out_item_t expected_pixels[$];
	logic mode_interp = 1'b1;
	logic mode_blend = 1'b1;
	logic gaps_on = 1'b1;
	int errors = 0;
	int checked = 0;
	longint cycles = 0;

	bilinear_sample_alpha_blend u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel_in(pixel_in),
		.done(done), .pixel_out(pixel_out), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] lane(input logic [31:0] w, input int k);
		return 64'((w >> (24 - 8 * k)) & 32'hFF);
	endfunction

	function automatic logic [63:0] clamp255(input logic [63:0] v);
		return (v > 255) ? 64'd255 : v;
	endfunction

	function automatic bsab_pkg::out_item_t blend_pixel(input bsab_pkg::in_item_t p,
			input logic ip, input logic bl);
		logic [63:0] fx, fy, s, sample[4], ch[4], va, da, inv, a, num, d, sum;
		bsab_pkg::out_item_t r;
		fx = 64'(p.frac_x);
		fy = 64'(p.frac_y);
		s = 64'd256;
		for (int k = 0; k < 4; k++) begin
			if (ip) begin
				sum = (lane(p.texel_top_left, k) * (s - fx) + lane(p.texel_top_right, k) * fx)
					* (s - fy) + (lane(p.texel_bottom_left, k) * (s - fx)
					+ lane(p.texel_bottom_right, k) * fx) * fy;
				sample[k] = (sum + 128) >> 8;
			end else begin
				sample[k] = lane(p.texel_top_left, k) << 8;
			end
			ch[k] = clamp255((sample[k] + 128) >> 8);
		end
		if (bl) begin
			va = sample[3];
			da = lane(p.dest_color, 3);
			inv = 255 * 256 - va;
			a = 255 * va + da * inv;
			ch[3] = clamp255((2 * a + 255 * 256) / (2 * 255 * 256));
			if (a != 0) begin
				for (int k = 0; k < 3; k++) begin
					num = 255 * sample[k] * va + lane(p.dest_color, k) * da * inv * 256;
					d = 256 * a;
					ch[k] = clamp255((2 * num + d) / (2 * d));
				end
			end
		end
		r.result_color = {ch[0][7:0], ch[1][7:0], ch[2][7:0], ch[3][7:0]};
		r.result_x = p.pixel_x;
		r.result_y = p.pixel_y;
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("** bilinear_sample_alpha_blend: FAILED **");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_pixels.push_back(blend_pixel(pixel_in, mode_interp, mode_blend));
				void'(pending_pixels.pop_front());
			end
			if (pending_pixels.size() > 0 && !(gaps_on && $urandom_range(99) < 16)) begin
				start <= 1'b1;
				pixel_in <= pending_pixels[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		bsab_pkg::out_item_t want;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h", $time, pixel_out);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				checked++;
				if (pixel_out.result_color !== want.result_color)
					$display("%0t: colour expected %h actual %h", $time,
						want.result_color, pixel_out.result_color);
				if (pixel_out.result_x !== want.result_x)
					$display("%0t: x expected %h actual %h", $time, want.result_x,
						pixel_out.result_x);
				if (pixel_out.result_y !== want.result_y)
					$display("%0t: y expected %h actual %h", $time, want.result_y,
						pixel_out.result_y);
				if (pixel_out !== want)
					errors++;
			end
		end
	end

	task automatic drain();
		while (pending_pixels.size() > 0 || start || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bsab_pkg::CFG_IDX_W-1:0] idx, input logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bsab_pkg::REG_INTERP)
			mode_interp = val;
		else
			mode_blend = val;
	endtask

	function automatic logic [31:0] rand_colour();
		logic [31:0] c;
		c = $urandom;
		case ($urandom_range(5))
			0: c[7:0] = 8'h00;
			1: c[7:0] = 8'hFF;
			default: ;
		endcase
		return c;
	endfunction

	task automatic add_random(input int n);
		bsab_pkg::in_item_t p;
		for (int i = 0; i < n; i++) begin
			p.texel_top_left = rand_colour();
			p.texel_top_right = rand_colour();
			p.texel_bottom_left = rand_colour();
			p.texel_bottom_right = rand_colour();
			p.frac_x = ($urandom_range(7) == 0) ? 8'($urandom_range(1) * 255) : 8'($urandom);
			p.frac_y = ($urandom_range(7) == 0) ? 8'($urandom_range(1) * 255) : 8'($urandom);
			p.dest_color = rand_colour();
			p.pixel_x = 12'($urandom);
			p.pixel_y = 12'($urandom);
			pending_pixels.push_back(p);
		end
	endtask

	task automatic add_directed();
		bsab_pkg::in_item_t p;
		logic [31:0] edges[4];
		edges = '{32'h0, 32'hFFFFFFFF, 32'hFF00FF00, 32'h00FF00FF};
		for (int i = 0; i < 16; i++) begin
			p.texel_top_left = edges[i % 4];
			p.texel_top_right = edges[(i / 4) % 4];
			p.texel_bottom_left = edges[(i + 1) % 4];
			p.texel_bottom_right = edges[(i + 2) % 4];
			p.frac_x = (i & 1) ? 8'hFF : 8'h00;
			p.frac_y = (i & 2) ? 8'hFF : 8'h80;
			p.dest_color = edges[(i + 3) % 4];
			p.pixel_x = (i & 4) ? 12'hFFF : 12'h000;
			p.pixel_y = (i & 8) ? 12'hFFF : 12'h000;
			pending_pixels.push_back(p);
		end
		// transparent sample over transparent destination keeps the sample colour
		p = '0;
		p.texel_top_left = 32'hC0FFEE00;
		p.texel_top_right = 32'h12345600;
		p.dest_color = 32'hABCDEF00;
		p.frac_x = 8'h40;
		pending_pixels.push_back(p);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int m = 3; m >= 0; m--) begin
			write_reg(bsab_pkg::REG_INTERP, m[1]);
			write_reg(bsab_pkg::REG_BLEND, m[0]);
			add_directed();
			drain();
		end
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(bsab_pkg::REG_INTERP, 1'($urandom));
			write_reg(bsab_pkg::REG_BLEND, 1'($urandom));
			gaps_on = (ph != 3);
			add_random(160);
			drain();
		end
		$display("checked %0d pixels over all four mode settings, directed edges then random",
			checked);
		if (errors == 0)
			$display("** bilinear_sample_alpha_blend: PASSED **");
		else
			$display("** bilinear_sample_alpha_blend: FAILED **");
		$finish;
	end
endmodule
